// ===== rtl/idm_pkg.sv =====
// Package: shared types, widths and sequencer codes of the 64-bit divide/modulo unit.
package idm_pkg;

  // Port field width and the width the arithmetic runs at.
  localparam int FieldWidth = 64;
  localparam int DataWidth  = 64;
  localparam int CntWidth   = $clog2(DataWidth);

  // Operation mode carried in cmd.
  localparam logic CmdUnsigned = 1'b0;
  localparam logic CmdSigned   = 1'b1;

  // One input transfer.
  typedef struct packed {
    logic                  cmd;
    logic [FieldWidth-1:0] dividend;
    logic [FieldWidth-1:0] divisor;
  } in_t;

  // One result transfer.
  typedef struct packed {
    logic [FieldWidth-1:0] quotient;
    logic [FieldWidth-1:0] remainder;
  } out_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    StIdle,
    StNegA,
    StNegB,
    StDiv,
    StNegQ,
    StNegR,
    StDone
  } state_e;

  // Work the shared subtractor does in a cycle.
  typedef enum logic [2:0] {
    OpNone,
    OpNegA,
    OpNegB,
    OpDiv,
    OpNegQ,
    OpNegR
  } op_e;

  // Control from sequencer to datapath and top level.
  typedef struct packed {
    logic idle;
    logic load;
    logic done;
    op_e  op;
  } ctrl_t;

endpackage

// ===== rtl/int64_divide_modulo_unit.sv =====
// Top level of the 64-bit signed/unsigned divide/modulo unit.
// Restoring divider returning quotient and remainder together, unsigned (cmd 0) or
// signed with truncation toward zero (cmd 1). A divide by zero gives zero for both
// results; the most negative value over minus one wraps to itself with remainder zero.
// One item occupies the unit from its input transfer to the next possible one:
// a single shared subtractor does operand sign fixup, dividend then divisor, one
// quotient bit per cycle, result sign fixup, quotient then remainder, then the
// result moves into the output register. in_stall_o stays high while an item is
// in flight; a result waiting in the output register does not block the next item,
// only the hand-off of the one after it.
module int64_divide_modulo_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  idm_pkg::in_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output idm_pkg::out_t out_data_o
);

  idm_pkg::ctrl_t                ctrl;
  logic                          in_fire;
  logic                          res_room;
  logic [idm_pkg::DataWidth-1:0] quot;
  logic [idm_pkg::DataWidth-1:0] rem;
  logic                          out_valid_q, out_valid_d;
  idm_pkg::out_t                 out_data_q, out_data_d;

  assign in_stall_o = ~ctrl.idle;
  assign in_fire    = in_valid_i & ctrl.idle;
  assign res_room   = ~out_valid_q | ~out_stall_i;

  idm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .res_room_i (res_room),
    .ctrl_o     (ctrl)
  );

  idm_datapath u_datapath (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .in_data_i (in_data_i),
    .quot_o    (quot),
    .rem_o     (rem)
  );

  // Load a finished result, drop the held one once transferred
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (ctrl.done && res_room) begin
      out_valid_d                                  = 1'b1;
      out_data_d.quotient                          = '0;
      out_data_d.remainder                         = '0;
      out_data_d.quotient[idm_pkg::DataWidth-1:0]  = quot;
      out_data_d.remainder[idm_pkg::DataWidth-1:0] = rem;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/idm_seq.sv =====
// Sequencer: walks one item through sign fixup, one quotient bit per cycle, and result fixup.
module idm_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_fire_i,
  input  logic          res_room_i,
  output idm_pkg::ctrl_t ctrl_o
);

  idm_pkg::state_e              state_q, state_d;
  logic [idm_pkg::CntWidth-1:0] cnt_q, cnt_d;

  // Hold state and bit counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= idm_pkg::StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Advance through the steps and drive datapath control
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ctrl_o.idle = 1'b0;
    ctrl_o.load = 1'b0;
    ctrl_o.done = 1'b0;
    ctrl_o.op   = idm_pkg::OpNone;
    case (state_q)
      idm_pkg::StIdle: begin
        ctrl_o.idle = 1'b1;
        if (in_fire_i) begin
          ctrl_o.load = 1'b1;
          state_d     = idm_pkg::StNegA;
        end
      end
      idm_pkg::StNegA: begin
        ctrl_o.op = idm_pkg::OpNegA;
        state_d   = idm_pkg::StNegB;
      end
      idm_pkg::StNegB: begin
        ctrl_o.op = idm_pkg::OpNegB;
        cnt_d     = idm_pkg::CntWidth'(idm_pkg::DataWidth - 1);
        state_d   = idm_pkg::StDiv;
      end
      idm_pkg::StDiv: begin
        ctrl_o.op = idm_pkg::OpDiv;
        cnt_d     = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = idm_pkg::StNegQ;
        end
      end
      idm_pkg::StNegQ: begin
        ctrl_o.op = idm_pkg::OpNegQ;
        state_d   = idm_pkg::StNegR;
      end
      idm_pkg::StNegR: begin
        ctrl_o.op = idm_pkg::OpNegR;
        state_d   = idm_pkg::StDone;
      end
      idm_pkg::StDone: begin
        ctrl_o.done = 1'b1;
        if (res_room_i) begin
          state_d = idm_pkg::StIdle;
        end
      end
      default: begin
        state_d = idm_pkg::StIdle;
      end
    endcase
  end

endmodule

// ===== rtl/idm_datapath.sv =====
// Datapath: operand registers around one shared subtractor used for negation and division.
module idm_datapath (
  input  logic                           clk_i,
  input  idm_pkg::ctrl_t                 ctrl_i,
  input  idm_pkg::in_t                   in_data_i,
  output logic [idm_pkg::DataWidth-1:0]  quot_o,
  output logic [idm_pkg::DataWidth-1:0]  rem_o
);

  localparam int W = idm_pkg::DataWidth;

  logic         a_neg_q, a_neg_d;
  logic         b_neg_q, b_neg_d;
  logic         den_zero_q, den_zero_d;
  logic [W-1:0] num_q, num_d;
  logic [W-1:0] den_q, den_d;
  logic [W-1:0] rem_q, rem_d;

  logic [W-1:0] op_a, op_b;
  logic [W:0]   sub_res;
  logic [W-1:0] shifted;
  logic         take;

  // Shared subtractor; top bit is the borrow
  assign sub_res = {1'b0, op_a} - {1'b0, op_b};

  // Partial remainder shifted left with the next dividend bit
  assign shifted = {rem_q[W-2:0], num_q[W-1]};
  // Subtract when the shifted-out bit is set or no borrow occurs
  assign take    = rem_q[W-1] | ~sub_res[W];

  // Select subtractor operands for the current step
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (ctrl_i.op)
      idm_pkg::OpNegA: op_b = num_q;
      idm_pkg::OpNegB: op_b = den_q;
      idm_pkg::OpDiv: begin
        op_a = shifted;
        op_b = den_q;
      end
      idm_pkg::OpNegQ: op_b = num_q;
      idm_pkg::OpNegR: op_b = rem_q;
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Next register values
  always_comb begin
    a_neg_d    = a_neg_q;
    b_neg_d    = b_neg_q;
    den_zero_d = den_zero_q;
    num_d      = num_q;
    den_d      = den_q;
    rem_d      = rem_q;
    if (ctrl_i.load) begin
      a_neg_d    = (in_data_i.cmd == idm_pkg::CmdSigned) & in_data_i.dividend[W-1];
      b_neg_d    = (in_data_i.cmd == idm_pkg::CmdSigned) & in_data_i.divisor[W-1];
      den_zero_d = (in_data_i.divisor[W-1:0] == '0);
      num_d      = in_data_i.dividend[W-1:0];
      den_d      = in_data_i.divisor[W-1:0];
      rem_d      = '0;
    end else begin
      case (ctrl_i.op)
        idm_pkg::OpNegA: if (a_neg_q) num_d = sub_res[W-1:0];
        idm_pkg::OpNegB: if (b_neg_q) den_d = sub_res[W-1:0];
        idm_pkg::OpDiv: begin
          rem_d = take ? sub_res[W-1:0] : shifted;
          num_d = {num_q[W-2:0], take};
        end
        idm_pkg::OpNegQ: if (a_neg_q ^ b_neg_q) num_d = sub_res[W-1:0];
        idm_pkg::OpNegR: if (a_neg_q) rem_d = sub_res[W-1:0];
        default: begin
          num_d = num_q;
        end
      endcase
    end
  end

  // Operand and result registers
  always_ff @(posedge clk_i) begin
    a_neg_q    <= a_neg_d;
    b_neg_q    <= b_neg_d;
    den_zero_q <= den_zero_d;
    num_q      <= num_d;
    den_q      <= den_d;
    rem_q      <= rem_d;
  end

  // Zero divisor forces both results to zero
  assign quot_o = den_zero_q ? '0 : num_q;
  assign rem_o  = den_zero_q ? '0 : rem_q;

endmodule

// ===== rtl/idm_checker.sv =====
// Checker: port-level properties of the divide/modulo unit, bound to the top level.
module idm_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input idm_pkg::out_t out_data_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // Go busy right after an input transfer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("unit not busy after input transfer");

  // A new result only appears at the end of an item in flight
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an item in flight");

  // Busy outlasts the check of a_busy_after_accept after an input transfer
  a_busy_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> ##1 in_stall_o)
    else $error("unit finished too early");

endmodule

bind int64_divide_modulo_unit idm_checker u_idm_checker (.*);

// ===== sim/tb.sv =====
// Testbench for the 64-bit divide/modulo unit: random and corner operands, bit-level checks.
module tb;

  localparam int W = idm_pkg::DataWidth;
  localparam logic [W-1:0] MinNeg = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MaxPos = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] AllOnes = '1;

  // Hold expected quotient/remainder pairs in transfer order and compare results.
  class divmod_scoreboard;
    idm_pkg::out_t divmod_expected[$];
    int   errors;
    int   accepted;
    int   checked;
    int   signed_seen;
    int   by_zero_seen;

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Shift-subtract division one quotient bit per step; the carry forces a subtract.
    function void restoring_divide(input logic [W-1:0] num, input logic [W-1:0] den,
                                   output logic [W-1:0] quo, output logic [W-1:0] rem);
      logic [W-1:0] part;
      logic         carry;
      quo  = '0;
      part = '0;
      if (den == '0) begin
        rem = '0;
        return;
      end
      for (int i = W - 1; i >= 0; i--) begin
        carry = part[W-1];
        part  = {part[W-2:0], num[i]};
        if (carry || part >= den) begin
          part   = part - den;
          quo[i] = 1'b1;
        end
      end
      rem = part;
    endfunction

    function idm_pkg::out_t predict_divmod(idm_pkg::in_t x);
      logic [W-1:0]  a;
      logic [W-1:0]  b;
      logic [W-1:0]  q;
      logic [W-1:0]  r;
      logic          a_neg;
      logic          b_neg;
      idm_pkg::out_t res;
      a     = x.dividend[W-1:0];
      b     = x.divisor[W-1:0];
      a_neg = (x.cmd == idm_pkg::CmdSigned) && a[W-1];
      b_neg = (x.cmd == idm_pkg::CmdSigned) && b[W-1];
      // Divide magnitudes, then fix the signs for truncating division.
      restoring_divide(a_neg ? '0 - a : a, b_neg ? '0 - b : b, q, r);
      if (a_neg != b_neg) q = '0 - q;
      if (a_neg) r = '0 - r;
      res = '0;
      res.quotient[W-1:0]  = q;
      res.remainder[W-1:0] = r;
      return res;
    endfunction

    function void note_operands(idm_pkg::in_t x);
      accepted++;
      if (x.cmd == idm_pkg::CmdSigned) signed_seen++;
      if (x.divisor[W-1:0] == '0) by_zero_seen++;
      divmod_expected.push_back(predict_divmod(x));
    endfunction

    task check_result(idm_pkg::out_t got);
      idm_pkg::out_t want;
      if (divmod_expected.size() == 0) begin
        report($sformatf("unexpected result q=%h r=%h", got.quotient, got.remainder));
        return;
      end
      want = divmod_expected.pop_front();
      checked++;
      if (got.quotient !== want.quotient)
        report($sformatf("result %0d quotient %h, expected %h", checked, got.quotient,
                         want.quotient));
      if (got.remainder !== want.remainder)
        report($sformatf("result %0d remainder %h, expected %h", checked, got.remainder,
                         want.remainder));
    endtask

    function int pending();
      return divmod_expected.size();
    endfunction
  endclass

  logic          clk_i     = 1'b0;
  logic          rst_ni    = 1'b0;
  logic          in_valid  = 1'b0;
  idm_pkg::in_t  in_data   = '0;
  logic          out_stall = 1'b0;
  logic          in_stall;
  logic          out_valid;
  idm_pkg::out_t out_data;

  int    gap_pct   = 0;
  int    stall_pct = 0;

  divmod_scoreboard sb;

  int64_divide_modulo_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #5 clk_i = ~clk_i;

  // Stall the result side at random.
  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Record input transfers and check result transfers.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) sb.note_operands(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Present one item, optionally after an idle gap, and hold it until the transfer.
  task automatic send_operands(input logic cmd, input logic [W-1:0] a,
                               input logic [W-1:0] b);
    idm_pkg::in_t item;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 90)) @(negedge clk_i);
    end
    item          = '0;
    item.cmd      = cmd;
    item.dividend = a;
    item.divisor  = b;
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  // Mix full-width, short, negative and boundary operands.
  function automatic logic [W-1:0] pick_operand();
    logic [W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      3, 4:    v = v >> $urandom_range(1, W - 1);
      5:       v = '0 - (v >> $urandom_range(1, W - 1));
      6:       v = v >> $urandom_range(W - 16, W - 1);
      7: begin
        case ($urandom_range(0, 4))
          0: v = '0;
          1: v = W'(1);
          2: v = AllOnes;
          3: v = MinNeg;
          default: v = MaxPos;
        endcase
      end
      default: v = v | MinNeg;
    endcase
    return v;
  endfunction

  task automatic send_random();
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic         cmd;
    cmd = $urandom_range(0, 1) ? idm_pkg::CmdSigned : idm_pkg::CmdUnsigned;
    a   = pick_operand();
    b   = pick_operand();
    case ($urandom_range(0, 24))
      0: b = '0;
      1: a = b * W'($urandom >> $urandom_range(0, 31));
      2: b = AllOnes;
      default: ;
    endcase
    send_operands(cmd, a, b);
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed corners, back to back.
    send_operands(idm_pkg::CmdUnsigned, '0, '0);
    send_operands(idm_pkg::CmdSigned, '0, '0);
    send_operands(idm_pkg::CmdUnsigned, AllOnes, '0);
    send_operands(idm_pkg::CmdSigned, MinNeg, '0);
    send_operands(idm_pkg::CmdUnsigned, '0, AllOnes);
    send_operands(idm_pkg::CmdUnsigned, AllOnes, W'(1));
    send_operands(idm_pkg::CmdUnsigned, AllOnes, AllOnes);
    send_operands(idm_pkg::CmdUnsigned, W'(1), AllOnes);
    send_operands(idm_pkg::CmdUnsigned, AllOnes, MinNeg);
    send_operands(idm_pkg::CmdUnsigned, MinNeg, W'(3));
    send_operands(idm_pkg::CmdSigned, MinNeg, AllOnes);
    send_operands(idm_pkg::CmdSigned, MinNeg, W'(1));
    send_operands(idm_pkg::CmdSigned, MinNeg, MinNeg);
    send_operands(idm_pkg::CmdSigned, MaxPos, MinNeg);
    send_operands(idm_pkg::CmdSigned, AllOnes, AllOnes);
    send_operands(idm_pkg::CmdSigned, '0 - W'(7), W'(2));
    send_operands(idm_pkg::CmdSigned, W'(7), '0 - W'(2));
    send_operands(idm_pkg::CmdSigned, '0 - W'(7), '0 - W'(2));
    send_operands(idm_pkg::CmdSigned, MaxPos, W'(1));
    send_operands(idm_pkg::CmdUnsigned, {(W/2){2'b10}}, {(W/2){2'b01}});
    send_operands(idm_pkg::CmdSigned, {(W/2){2'b01}}, {(W/2){2'b10}});
    send_operands(idm_pkg::CmdUnsigned, W'(5), 64'h0000_0001_0000_0000);
    drain();

    // Random phases: no idling, sender gaps, result stalls, both.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 50; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 50; end
        default: begin gap_pct = 18; stall_pct = 18; end
      endcase
      repeat (95) send_random();
      drain();
    end

    // Let the unit settle, then flag anything still owed.
    stall_pct = 0;
    repeat (80) @(negedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("Covered %0d transfers (%0d signed, %0d with a zero divisor), %0d results checked",
             sb.accepted, sb.signed_seen, sb.by_zero_seen, sb.checked);
    $display("across idle, sender-gap, result-stall and mixed handshake phases");
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Bound the run well past the slowest legal completion.
  initial begin
    #(10 * 1_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
